/* hdl/cak_pkg.sv */
// Shared types and constants for the cellular automaton keystream unit.
// Used by cak_step and cellular_automaton_keystream_unit; no dependencies.
package cak_pkg;

    localparam int RULE_W     = 8;
    localparam int TAP_W      = 3;
    localparam int CHAR_W     = 7;
    localparam int BYTE_W     = 8;
    localparam int INDEX_W    = 5;
    localparam int CFG_ADDR_W = 1;

    // Configuration register indexes
    localparam logic [CFG_ADDR_W-1:0] REG_RULE = 1'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_TAP  = 1'd1;

    localparam logic [RULE_W-1:0] RULE_RESET = 8'd30;
    localparam logic [TAP_W-1:0]  TAP_RESET  = 3'd0;

    // Rule and tap, shared by every step stage
    typedef struct packed {
        logic [RULE_W-1:0] rule;
        logic [TAP_W-1:0]  tap;
    } cak_cfg_t;

endpackage

/* hdl/cak_step.sv */
// One automaton step over the whole ring, plus the sampled tap bit.
// Depends on cak_pkg for the configuration struct.
module cak_step #(
    parameter int CELLS = 7
) (
    input  cak_pkg::cak_cfg_t cfg,
    input  logic [CELLS-1:0]  ring_in,
    output logic [CELLS-1:0]  ring_out,
    output logic              tap_bit
);
    import cak_pkg::*;

    // Look up each cell's next value; the rule is indexed by the bitwise-inverted neighbourhood
    always_comb begin
        for (int j = 0; j < CELLS; j++) begin
            ring_out[j] = cfg.rule[~{ring_in[(j + CELLS - 1) % CELLS],
                                     ring_in[j],
                                     ring_in[(j + 1) % CELLS]}];
        end
    end

    // Sample the tapped cell after the step
    always_comb begin
        tap_bit = 1'b0;
        for (int j = 0; j < CELLS; j++) begin
            if (int'(cfg.tap) == j) begin
                tap_bit = ring_out[j];
            end
        end
    end

endmodule

/* hdl/cellular_automaton_keystream_unit.sv */
// Keystream unit: seeds a ring of CELLS cells from a character, then runs STEPS
// automaton steps through a row of eight step stages, emitting one byte per cycle unless m_tready stalls it.
// The character is seeded into the ring register; the first byte then goes to the output register.
// Each character yields ceil(STEPS/8) bytes (32 at defaults) from the eight-stage step row;
// the next character is taken as the last byte is formed.
// Reset (aresetn low, synchronous): pipeline empty, rule = 30, tap = 0.
module cellular_automaton_keystream_unit #(
    parameter int STEPS = 256,
    parameter int CELLS = 7
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    // configuration write port
    input  logic                                  cfg_wr_en,
    input  logic [cak_pkg::CFG_ADDR_W-1:0]        cfg_addr,
    input  logic [cak_pkg::RULE_W-1:0]            cfg_wdata,
    // input characters
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    input  logic [7:0]                            s_tdata,   // [6:0] plain_char, [7] zero
    // key bytes
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    output logic [15:0]                           m_tdata,   // [7:0] key_byte,
                                                             // [12:8] byte_index, [15:13] zero
    output logic                                  m_tlast    // last
);
    import cak_pkg::*;

    localparam int NB        = (STEPS + 7) / 8;
    localparam int CW        = (NB > 1) ? $clog2(NB) : 1;
    localparam int LAST_BITS = STEPS - 8 * (NB - 1);

    cak_cfg_t             cfg_reg;
    logic                 busy_reg;
    logic [CW-1:0]        cnt_reg;
    logic [CELLS-1:0]     ring_reg;
    logic                 out_valid_reg;
    logic [BYTE_W-1:0]    out_byte_reg;
    logic [INDEX_W-1:0]   out_index_reg;
    logic                 out_last_reg;

    logic [CELLS-1:0]     ring_chain [0:8];
    logic [BYTE_W-1:0]    tap_bits;
    logic [BYTE_W-1:0]    byte_next;
    logic [CELLS-1:0]     seed_next;
    logic                 adv;
    logic                 at_last;
    logic                 s_xfer;

    // Configuration registers; clamp the tap to the last cell
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.rule <= RULE_RESET;
            cfg_reg.tap  <= TAP_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                REG_RULE: cfg_reg.rule <= cfg_wdata;
                REG_TAP: begin
                    if (int'(cfg_wdata[TAP_W-1:0]) > CELLS - 1) begin
                        cfg_reg.tap <= TAP_W'(CELLS - 1);
                    end else begin
                        cfg_reg.tap <= cfg_wdata[TAP_W-1:0];
                    end
                end
                default: ;
            endcase
        end
    end

    // Row of eight step stages from the ring register
    assign ring_chain[0] = ring_reg;
    for (genvar k = 0; k < 8; k++) begin : g_step
        cak_step #(.CELLS(CELLS)) u_step (
            .cfg      (cfg_reg),
            .ring_in  (ring_chain[k]),
            .ring_out (ring_chain[k+1]),
            .tap_bit  (tap_bits[k])
        );
    end

    assign at_last = (cnt_reg == CW'(NB - 1));

    // Pack sampled bits, earliest in bit 7; zero the unused tail of a short last byte
    always_comb begin
        for (int k = 0; k < 8; k++) begin
            byte_next[7-k] = tap_bits[k];
            if (at_last && k >= LAST_BITS) begin
                byte_next[7-k] = 1'b0;
            end
        end
    end

    // Seed: cell j takes character bit CELLS-1-j where that bit exists
    always_comb begin
        for (int j = 0; j < CELLS; j++) begin
            seed_next[j] = 1'b0;
            if (CELLS - 1 - j < CHAR_W) begin
                seed_next[j] = s_tdata[(CELLS - 1 - j) % CHAR_W];
            end
        end
    end

    assign adv      = busy_reg && (!out_valid_reg || m_tready);
    assign s_tready = !busy_reg || (adv && at_last);
    assign s_xfer   = s_tvalid && s_tready;

    // Advance the ring one byte per cycle unless the output stalls; load a new seed on transfer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (s_xfer) begin
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
        end else if (adv) begin
            if (at_last) begin
                busy_reg <= 1'b0;
            end
            cnt_reg <= cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_xfer) begin
            ring_reg <= seed_next;
        end else if (adv) begin
            ring_reg <= ring_chain[8];
        end
    end

    // Output register: hold until the downstream transfer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (adv) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            out_byte_reg  <= byte_next;
            out_index_reg <= INDEX_W'(cnt_reg);
            out_last_reg  <= at_last;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'b000, out_index_reg, out_byte_reg};
    assign m_tlast  = out_last_reg;

endmodule
